>>> rtl/bsl_pkg.sv
// Shared constants, token kinds, keyword table and action record of the source lexer.
package bsl_pkg;

  // Lexer modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_COMMENT  = 4'd1;
  localparam logic [3:0] M_ID       = 4'd2;
  localparam logic [3:0] M_NUM      = 4'd3;
  localparam logic [3:0] M_FRAC     = 4'd4;
  localparam logic [3:0] M_ZERO     = 4'd5;
  localparam logic [3:0] M_AMP      = 4'd6;
  localparam logic [3:0] M_HEX      = 4'd7;
  localparam logic [3:0] M_GT       = 4'd8;
  localparam logic [3:0] M_LT       = 4'd9;
  localparam logic [3:0] M_STR_OPEN = 4'd10;
  localparam logic [3:0] M_STR_ONE  = 4'd11;
  localparam logic [3:0] M_STR_TWO  = 4'd12;
  localparam logic [3:0] M_STR_BODY = 4'd13;

  // Token kinds
  localparam logic [6:0] K_LINEEND   = 7'd0;
  localparam logic [6:0] K_FILEEND   = 7'd1;
  localparam logic [6:0] K_NUM       = 7'd2;
  localparam logic [6:0] K_DOUBLENUM = 7'd3;
  localparam logic [6:0] K_ID        = 7'd4;
  localparam logic [6:0] K_STR       = 7'd5;
  localparam logic [6:0] K_CHAR      = 7'd6;
  localparam logic [6:0] K_ERROR     = 7'd7;
  localparam logic [6:0] K_OP0       = 7'd8;
  localparam logic [6:0] K_EQ        = 7'd24;
  localparam logic [6:0] K_GT        = 7'd25;
  localparam logic [6:0] K_GE        = 7'd26;
  localparam logic [6:0] K_LT        = 7'd27;
  localparam logic [6:0] K_LE        = 7'd28;
  localparam logic [6:0] K_NE        = 7'd29;
  localparam logic [6:0] K_KW0       = 7'd30;

  localparam int NKW = 47;
  localparam int LINE_OUT_W = 16;
  localparam int TDATA_W = 64;
  localparam int TUSER_W = 8;

  // Line counter update after a token
  localparam logic [1:0] LN_KEEP  = 2'd0;
  localparam logic [1:0] LN_INC   = 2'd1;
  localparam logic [1:0] LN_RESET = 2'd2;

  localparam logic [63:0] KW_TXT [NKW] = '{
    "if", "then", "else", "elseif", "do", "while", "wend", "loop", "for",
    "to", "step", "next", "exit", "return", "select", "case", "default",
    "dim", "new", "shared", "as", "erase", "free", "function", "sub",
    "type", "declare", "native", "end", "and", "or", "not", "mod",
    "string", "integer", "byte", "short", "long", "boolean", "double",
    "float", "date", "include", "const", "null", "true", "false"
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd2, 4'd4, 4'd4, 4'd6, 4'd2, 4'd5, 4'd4, 4'd4, 4'd3,
    4'd2, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd7,
    4'd3, 4'd3, 4'd6, 4'd2, 4'd5, 4'd4, 4'd8, 4'd3,
    4'd4, 4'd7, 4'd6, 4'd3, 4'd3, 4'd2, 4'd3, 4'd3,
    4'd6, 4'd7, 4'd4, 4'd5, 4'd4, 4'd7, 4'd6,
    4'd5, 4'd4, 4'd7, 4'd5, 4'd4, 4'd4, 4'd5
  };

  // One feed step's decisions
  typedef struct packed {
    logic [3:0] mode;
    logic       clr;
    logic       app;
    logic [7:0] app_ch;
    logic       emit;
    logic [6:0] kind;
    logic       use_hex;
    logic       refeed;
    logic [1:0] line_op;
    logic       held_we;
    logic       hex_we;
    logic [3:0] hex_nib;
  } scan_act_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Single-character operator kind, 0 when none
  function automatic logic [6:0] op_kind(logic [7:0] c);
    logic [6:0] k;
    k = 7'd0;
    case (c)
      "+": k = K_OP0;
      "-": k = K_OP0 + 7'd1;
      "*": k = K_OP0 + 7'd2;
      "/": k = K_OP0 + 7'd3;
      "(": k = K_OP0 + 7'd4;
      ")": k = K_OP0 + 7'd5;
      "[": k = K_OP0 + 7'd6;
      "]": k = K_OP0 + 7'd7;
      "{": k = K_OP0 + 7'd8;
      "}": k = K_OP0 + 7'd9;
      ";": k = K_OP0 + 7'd10;
      ".": k = K_OP0 + 7'd11;
      ",": k = K_OP0 + 7'd12;
      "$": k = K_OP0 + 7'd13;
      "#": k = K_OP0 + 7'd14;
      ":": k = K_OP0 + 7'd15;
      "=": k = K_EQ;
      default: k = 7'd0;
    endcase
    return k;
  endfunction

  // Keyword lookup on lower-case text, first char in the top byte
  function automatic logic [6:0] kw_kind(logic [63:0] word, logic [3:0] len);
    logic [6:0] k;
    k = K_ID;
    for (int i = 0; i < NKW; i++) begin
      if (len == KW_LEN[i] && (KW_TXT[i] << (8 * (8 - int'(KW_LEN[i])))) == word) begin
        k = K_KW0 + 7'(i);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/basic_source_lexer.sv
// Source lexer top level: byte input, token buffer RAM, beat output register.
//
// Usage: source bytes enter on the s_axis channel, one byte per beat; byte 0
// ends the text. Tokens leave on the m_axis channel, one beat per character
// of token text, tlast on the final beat of each token, the token kind and
// the text-valid flag in tuser. A token without text (line end, file end,
// hex number, empty string) is a single beat with text_valid low.
// Flow: a byte is accepted only while idle and then scanned in its mode
// (a byte that closes a token is scanned a second time in the next mode).
// Each character of a token is read from the buffer RAM and then loaded
// into the output register; a token without text goes straight to the
// output load. The token buffer is a single RAM with a registered read.
// Text beyond TOKEN_MAX characters is dropped and flagged as truncated.
// Reset: idle between tokens, line counter at 1, no beat pending.
// Stall: while the output beat is not taken, emission holds and no new
// byte is accepted until the token is out.
module basic_source_lexer #(
  parameter int TOKEN_MAX = 32,
  parameter int LINE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] text_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] text_char, [23:8] line_number, [55:24] hex_value,
  // [56] text_truncated, [63:57] zero
  output logic [bsl_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [bsl_pkg::TUSER_W-1:0] m_axis_tuser,   // [6:0] token_kind, [7] text_valid
  output logic                        m_axis_tlast    // token_last
);

  localparam int AW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
  localparam int LW = $clog2(TOKEN_MAX + 1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_FEED = 2'd1;
  localparam logic [1:0] P_RD   = 2'd2;
  localparam logic [1:0] P_OUT  = 2'd3;

  logic [1:0]           phase_q, phase_d;
  logic [7:0]           byte_q;
  logic [3:0]           mode_q;
  logic [7:0]           held_q;
  logic [31:0]          hex_q;
  logic [LW-1:0]        len_q;
  logic                 ovf_q;
  logic [LINE_BITS-1:0] line_q;
  logic [7:0]           kw_q [8];

  // emission context
  logic [6:0]           ekind_q;
  logic [31:0]          ehex_q;
  logic                 erefeed_q;
  logic [1:0]           eline_q;
  logic [LW-1:0]        idx_q;

  // output register
  logic                          mv_q;
  logic [bsl_pkg::TDATA_W-1:0]   mdata_q;
  logic [bsl_pkg::TUSER_W-1:0]   muser_q;
  logic                          mlast_q;

  bsl_pkg::scan_act_t   act;
  logic [63:0]          kw_word;
  logic [3:0]           kw_len;
  logic [LW-1:0]        base_len, new_len;
  logic                 base_ovf, new_ovf;
  logic                 ram_we;
  logic [7:0]           rdata;
  logic                 feed;
  logic                 load;
  logic                 beat_last;
  logic [31:0]          line_ext;

  // keyword compare word from the first eight buffered characters
  always_comb begin
    kw_word = '0;
    for (int i = 0; i < 8; i++) begin
      if (LW'(i) < len_q) kw_word[63-8*i -: 8] = kw_q[i];
    end
    kw_len = (len_q > LW'(8)) ? 4'hF : 4'(len_q);
  end

  bsl_scan u_scan (
    .byte_i    (byte_q),
    .mode_i    (mode_q),
    .held_i    (held_q),
    .kw_word_i (kw_word),
    .kw_len_i  (kw_len),
    .ovf_i     (ovf_q),
    .act_o     (act)
  );

  assign feed = (phase_q == P_FEED);

  // append into the buffer
  always_comb begin
    base_len = act.clr ? '0 : len_q;
    base_ovf = act.clr ? 1'b0 : ovf_q;
    new_len  = base_len;
    new_ovf  = base_ovf;
    ram_we   = 1'b0;
    if (act.app) begin
      if (base_len < LW'(TOKEN_MAX)) begin
        ram_we  = feed;
        new_len = base_len + LW'(1);
      end else begin
        new_ovf = 1'b1;
      end
    end
  end

  bsl_ram #(.Width(8), .Depth(TOKEN_MAX)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(base_len)),
    .wdata_i (act.app_ch),
    .raddr_i (AW'(idx_q)),
    .rdata_o (rdata)
  );

  assign load      = (phase_q == P_OUT) && (!mv_q || m_axis_tready);
  assign beat_last = (len_q == '0) || (idx_q + LW'(1) == len_q);
  assign line_ext  = 32'(line_q);

  // sequencer
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      P_IDLE: if (s_axis_tvalid) phase_d = P_FEED;
      P_FEED: begin
        if (act.emit)        phase_d = (new_len == '0) ? P_OUT : P_RD;
        else if (act.refeed) phase_d = P_FEED;
        else                 phase_d = P_IDLE;
      end
      P_RD:   phase_d = P_OUT;
      P_OUT: begin
        if (load) begin
          if (!beat_last)     phase_d = P_RD;
          else if (erefeed_q) phase_d = P_FEED;
          else                phase_d = P_IDLE;
        end
      end
      default: phase_d = P_IDLE;
    endcase
  end

  assign s_axis_tready = (phase_q == P_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      mode_q  <= bsl_pkg::M_IDLE;
      held_q  <= '0;
      hex_q   <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      line_q  <= LINE_BITS'(1);
      mv_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (s_axis_tvalid && s_axis_tready) byte_q <= s_axis_tdata;

      // one scan step
      if (feed) begin
        mode_q <= act.mode;
        len_q  <= new_len;
        ovf_q  <= new_ovf;
        if (act.clr) hex_q <= '0;
        if (act.hex_we) hex_q <= {hex_q[27:0], act.hex_nib};
        if (act.held_we) held_q <= byte_q;
        if (ram_we && base_len < LW'(8)) kw_q[3'(base_len)] <= bsl_pkg::to_lower(act.app_ch);
        if (act.emit) begin
          ekind_q   <= act.kind;
          ehex_q    <= act.use_hex ? hex_q : '0;
          erefeed_q <= act.refeed;
          eline_q   <= act.line_op;
          idx_q     <= '0;
        end
      end

      // beat output and token wrap-up
      if (load) begin
        mv_q    <= 1'b1;
        mlast_q <= beat_last;
        mdata_q <= {7'd0, ovf_q, ehex_q, line_ext[bsl_pkg::LINE_OUT_W-1:0],
                    (len_q != '0) ? rdata : 8'd0};
        muser_q <= {(len_q != '0), ekind_q};
        if (beat_last) begin
          len_q <= '0;
          ovf_q <= 1'b0;
          hex_q <= '0;
          if (eline_q == bsl_pkg::LN_INC && line_q != LINE_MAX) line_q <= line_q + 1'b1;
          if (eline_q == bsl_pkg::LN_RESET) line_q <= LINE_BITS'(1);
        end else begin
          idx_q <= idx_q + LW'(1);
        end
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;
  assign m_axis_tlast  = mlast_q;

  // A beat without text always ends its token
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[7] |-> m_axis_tlast)
    else $error("text-less beat without tlast");

  // Buffer fill never passes its depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(TOKEN_MAX))
    else $error("token length beyond buffer");

  // Line counter never wraps to zero
  a_line_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter is zero");

  // No byte accepted while a token is being read out
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_RD || phase_q == P_OUT) |-> !s_axis_tready)
    else $error("byte accepted during emission");

endmodule

>>> rtl/bsl_ram.sv
// Generic single-port-write, registered-read RAM.
module bsl_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/bsl_scan.sv
// Next-step decode of the lexer: one source byte against the current mode.
module bsl_scan (
  input  logic [7:0]         byte_i,
  input  logic [3:0]         mode_i,
  input  logic [7:0]         held_i,
  input  logic [63:0]        kw_word_i,
  input  logic [3:0]         kw_len_i,
  input  logic               ovf_i,
  output bsl_pkg::scan_act_t act_o
);

  logic [7:0] c;
  logic [6:0] op;
  logic [3:0] hnib;
  logic       hvalid;

  assign c  = byte_i;
  assign op = bsl_pkg::op_kind(c);

  // hex digit value
  always_comb begin
    hvalid = 1'b1;
    hnib   = 4'd0;
    if (c >= "0" && c <= "9")      hnib = 4'(c - "0");
    else if (c >= "A" && c <= "F") hnib = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") hnib = 4'(c - "a" + 8'd10);
    else                           hvalid = 1'b0;
  end

  always_comb begin
    act_o         = '0;
    act_o.mode    = mode_i;
    act_o.app_ch  = c;
    act_o.line_op = bsl_pkg::LN_KEEP;
    act_o.hex_nib = hnib;
    unique case (mode_i)
      bsl_pkg::M_COMMENT: begin
        if (c == 8'h0A || c == 8'h00) begin
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_ID: begin
        if (bsl_pkg::is_letter(c) || bsl_pkg::is_digit(c)) begin
          act_o.app = 1'b1;
        end else begin
          act_o.emit   = 1'b1;
          act_o.kind   = ovf_i ? bsl_pkg::K_ID : bsl_pkg::kw_kind(kw_word_i, kw_len_i);
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_ZERO: begin
        if (c == "x") begin
          act_o.clr  = 1'b1;
          act_o.mode = bsl_pkg::M_HEX;
        end else begin
          act_o.mode   = bsl_pkg::M_NUM;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_NUM: begin
        if (bsl_pkg::is_digit(c)) begin
          act_o.app = 1'b1;
        end else if (c == ".") begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_FRAC;
        end else begin
          act_o.emit   = 1'b1;
          act_o.kind   = bsl_pkg::K_NUM;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_FRAC: begin
        if (bsl_pkg::is_digit(c)) begin
          act_o.app = 1'b1;
        end else begin
          act_o.emit   = 1'b1;
          act_o.kind   = bsl_pkg::K_DOUBLENUM;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_AMP: begin
        if (c == "H") begin
          act_o.clr  = 1'b1;
          act_o.mode = bsl_pkg::M_HEX;
        end else begin
          act_o.emit   = 1'b1;
          act_o.kind   = bsl_pkg::K_ERROR;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_HEX: begin
        if (hvalid) begin
          act_o.hex_we = 1'b1;
        end else begin
          act_o.emit    = 1'b1;
          act_o.kind    = bsl_pkg::K_NUM;
          act_o.use_hex = 1'b1;
          act_o.mode    = bsl_pkg::M_IDLE;
          act_o.refeed  = 1'b1;
        end
      end
      bsl_pkg::M_GT: begin
        act_o.mode = bsl_pkg::M_IDLE;
        act_o.emit = 1'b1;
        if (c == "=") begin
          act_o.app  = 1'b1;
          act_o.kind = bsl_pkg::K_GE;
        end else begin
          act_o.kind   = bsl_pkg::K_GT;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_LT: begin
        act_o.mode = bsl_pkg::M_IDLE;
        act_o.emit = 1'b1;
        if (c == "=") begin
          act_o.app  = 1'b1;
          act_o.kind = bsl_pkg::K_LE;
        end else if (c == ">") begin
          act_o.app  = 1'b1;
          act_o.kind = bsl_pkg::K_NE;
        end else begin
          act_o.kind   = bsl_pkg::K_LT;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_STR_OPEN: begin
        if (c == 8'h00) begin
          act_o.emit   = 1'b1;
          act_o.kind   = bsl_pkg::K_STR;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end else begin
          act_o.held_we = 1'b1;
          act_o.mode    = bsl_pkg::M_STR_ONE;
        end
      end
      bsl_pkg::M_STR_ONE: begin
        act_o.app_ch = held_i;
        if (c == "\"") begin
          act_o.mode = bsl_pkg::M_STR_TWO;
        end else if (held_i == "\"") begin
          act_o.emit   = 1'b1;
          act_o.kind   = bsl_pkg::K_STR;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end else begin
          act_o.app    = 1'b1;
          act_o.mode   = bsl_pkg::M_STR_BODY;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_STR_TWO: begin
        act_o.app_ch = held_i;
        act_o.emit   = 1'b1;
        if (c == "C" || c == "c") begin
          act_o.app  = 1'b1;
          act_o.kind = bsl_pkg::K_CHAR;
          act_o.mode = bsl_pkg::M_IDLE;
        end else if (held_i == "\"") begin
          act_o.kind   = bsl_pkg::K_STR;
          act_o.mode   = bsl_pkg::M_STR_OPEN;
          act_o.refeed = 1'b1;
        end else begin
          act_o.app    = 1'b1;
          act_o.kind   = bsl_pkg::K_STR;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = 1'b1;
        end
      end
      bsl_pkg::M_STR_BODY: begin
        if (c == "\"" || c == 8'h00) begin
          act_o.emit   = 1'b1;
          act_o.kind   = bsl_pkg::K_STR;
          act_o.mode   = bsl_pkg::M_IDLE;
          act_o.refeed = (c == 8'h00);
        end else begin
          act_o.app = 1'b1;
        end
      end
      default: begin
        // between tokens: start a new one
        act_o.mode = bsl_pkg::M_IDLE;
        act_o.clr  = 1'b1;
        if (c == " " || c == 8'h09 || c == 8'h0D) begin
          act_o.mode = bsl_pkg::M_IDLE;
        end else if (c == "'") begin
          act_o.mode = bsl_pkg::M_COMMENT;
        end else if (c == 8'h00) begin
          act_o.emit    = 1'b1;
          act_o.kind    = bsl_pkg::K_FILEEND;
          act_o.line_op = bsl_pkg::LN_RESET;
        end else if (c == 8'h0A) begin
          act_o.emit    = 1'b1;
          act_o.kind    = bsl_pkg::K_LINEEND;
          act_o.line_op = bsl_pkg::LN_INC;
        end else if (op != 7'd0) begin
          act_o.app  = 1'b1;
          act_o.emit = 1'b1;
          act_o.kind = op;
        end else if (c == "&") begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_AMP;
        end else if (c == ">") begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_GT;
        end else if (c == "<") begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_LT;
        end else if (c == "\"") begin
          act_o.mode = bsl_pkg::M_STR_OPEN;
        end else if (c == "0") begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_ZERO;
        end else if (bsl_pkg::is_digit(c)) begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_NUM;
        end else if (bsl_pkg::is_letter(c)) begin
          act_o.app  = 1'b1;
          act_o.mode = bsl_pkg::M_ID;
        end else begin
          act_o.app  = 1'b1;
          act_o.emit = 1'b1;
          act_o.kind = bsl_pkg::K_ERROR;
        end
      end
    endcase
  end

endmodule

>>> test/tb_basic_source_lexer.sv
// Self-checking testbench for basic_source_lexer: random source text against a token predictor.
`timescale 1ns / 100ps

module tb_basic_source_lexer;

  // One output beat as the lexer should produce it
  typedef struct {
    logic [6:0]  kind;
    logic [7:0]  ch;
    logic        valid;
    logic        last;
    logic [15:0] line;
    logic [31:0] hex;
    logic        trunc;
  } tok_beat_t;

  localparam int TOK_MAX = 32;
  localparam int N_ITEMS = 430;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;

  basic_source_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  string kw_list [47] = '{
    "if", "then", "else", "elseif", "do", "while", "wend", "loop", "for",
    "to", "step", "next", "exit", "return", "select", "case", "default",
    "dim", "new", "shared", "as", "erase", "free", "function", "sub",
    "type", "declare", "native", "end", "and", "or", "not", "mod",
    "string", "integer", "byte", "short", "long", "boolean", "double",
    "float", "date", "include", "const", "null", "true", "false"
  };
  string op_list = "+-*/()[]{};.,$#:";

  logic [7:0]  src_q [$];
  tok_beat_t   beat_q [$];

  // Predictor state
  logic [3:0]  lx_mode = bsl_pkg::M_IDLE;
  logic [7:0]  lx_buf [TOK_MAX];
  int          lx_len = 0;
  logic [15:0] lx_line = 16'd1;
  logic [31:0] lx_hex = 32'd0;
  logic [7:0]  lx_held = 8'd0;
  logic        lx_ovf = 1'b0;

  int n_sent = 0, n_beats = 0, n_tokens = 0, n_err = 0;
  int thr1 = 0, thr2 = 0;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (is_num(c)) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    return -1;
  endfunction

  function automatic logic [6:0] single_op_kind(logic [7:0] c);
    for (int i = 0; i < 16; i++)
      if (op_list[i] == c) return bsl_pkg::K_OP0 + 7'(i);
    if (c == 8'h3d) return bsl_pkg::K_EQ;
    return 7'd0;
  endfunction

  function automatic void push_beat(logic [6:0] k, logic [7:0] c, logic v, logic l,
                                    logic [31:0] h);
    tok_beat_t b;
    b.kind = k; b.ch = c; b.valid = v; b.last = l;
    b.line = lx_line; b.hex = h; b.trunc = lx_ovf;
    beat_q.push_back(b);
  endfunction

  function automatic void buf_add(logic [7:0] c);
    if (lx_len < TOK_MAX) begin
      lx_buf[lx_len] = c;
      lx_len++;
    end else begin
      lx_ovf = 1'b1;
    end
  endfunction

  function automatic void tok_clear();
    lx_len = 0; lx_ovf = 1'b0; lx_hex = 32'd0;
  endfunction

  function automatic void tok_out(logic [6:0] k, logic [31:0] h);
    if (lx_len == 0) push_beat(k, 8'd0, 1'b0, 1'b1, h);
    for (int i = 0; i < lx_len; i++) push_beat(k, lx_buf[i], 1'b1, i + 1 == lx_len, h);
    tok_clear();
  endfunction

  // Keyword match on the buffered identifier, case folded
  function automatic logic [6:0] ident_kind();
    logic [7:0] b;
    bit same;
    if (lx_ovf) return bsl_pkg::K_ID;
    for (int k = 0; k < 47; k++) begin
      if (kw_list[k].len() == lx_len) begin
        same = 1;
        for (int i = 0; i < lx_len; i++) begin
          b = lx_buf[i];
          if (b >= 8'h41 && b <= 8'h5a) b = b + 8'd32;
          if (b != kw_list[k][i]) same = 0;
        end
        if (same) return bsl_pkg::K_KW0 + 7'(k);
      end
    end
    return bsl_pkg::K_ID;
  endfunction

  function automatic void tok_begin(logic [7:0] c);
    logic [6:0] op;
    op = single_op_kind(c);
    tok_clear();
    if (c == 8'h20 || c == 8'h09 || c == 8'h0d) return;
    if (c == 8'h27) begin lx_mode = bsl_pkg::M_COMMENT; return; end
    if (c == 8'h00) begin
      tok_out(bsl_pkg::K_FILEEND, 32'd0);
      lx_line = 16'd1;
      return;
    end
    if (c == 8'h0a) begin
      tok_out(bsl_pkg::K_LINEEND, 32'd0);
      if (lx_line != 16'hffff) lx_line++;
      return;
    end
    if (op != 7'd0) begin buf_add(c); tok_out(op, 32'd0); return; end
    buf_add(c);
    if (c == 8'h26) lx_mode = bsl_pkg::M_AMP;
    else if (c == 8'h3e) lx_mode = bsl_pkg::M_GT;
    else if (c == 8'h3c) lx_mode = bsl_pkg::M_LT;
    else if (c == 8'h22) begin tok_clear(); lx_mode = bsl_pkg::M_STR_OPEN; end
    else if (c == 8'h30) lx_mode = bsl_pkg::M_ZERO;
    else if (is_num(c)) lx_mode = bsl_pkg::M_NUM;
    else if (is_alpha(c)) lx_mode = bsl_pkg::M_ID;
    else tok_out(bsl_pkg::K_ERROR, 32'd0);
  endfunction

  // One scan step; returns 1 when the byte is scanned again in the new mode
  function automatic bit scan_step(logic [7:0] c);
    int d;
    case (lx_mode)
      bsl_pkg::M_COMMENT: begin
        if (c == 8'h0a || c == 8'h00) begin lx_mode = bsl_pkg::M_IDLE; return 1; end
        return 0;
      end
      bsl_pkg::M_ID: begin
        if (is_alpha(c) || is_num(c)) begin buf_add(c); return 0; end
        tok_out(ident_kind(), 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
      end
      bsl_pkg::M_ZERO: begin
        if (c == 8'h78) begin tok_clear(); lx_mode = bsl_pkg::M_HEX; return 0; end
        lx_mode = bsl_pkg::M_NUM; return 1;
      end
      bsl_pkg::M_NUM: begin
        if (is_num(c)) begin buf_add(c); return 0; end
        if (c == 8'h2e) begin buf_add(c); lx_mode = bsl_pkg::M_FRAC; return 0; end
        tok_out(bsl_pkg::K_NUM, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
      end
      bsl_pkg::M_FRAC: begin
        if (is_num(c)) begin buf_add(c); return 0; end
        tok_out(bsl_pkg::K_DOUBLENUM, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
      end
      bsl_pkg::M_AMP: begin
        if (c == 8'h48) begin tok_clear(); lx_mode = bsl_pkg::M_HEX; return 0; end
        tok_out(bsl_pkg::K_ERROR, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
      end
      bsl_pkg::M_HEX: begin
        d = hex_nibble(c);
        if (d >= 0) begin lx_hex = {lx_hex[27:0], 4'(d)}; return 0; end
        tok_out(bsl_pkg::K_NUM, lx_hex); lx_mode = bsl_pkg::M_IDLE; return 1;
      end
      bsl_pkg::M_GT: begin
        lx_mode = bsl_pkg::M_IDLE;
        if (c == 8'h3d) begin buf_add(c); tok_out(bsl_pkg::K_GE, 32'd0); return 0; end
        tok_out(bsl_pkg::K_GT, 32'd0); return 1;
      end
      bsl_pkg::M_LT: begin
        lx_mode = bsl_pkg::M_IDLE;
        if (c == 8'h3d) begin buf_add(c); tok_out(bsl_pkg::K_LE, 32'd0); return 0; end
        if (c == 8'h3e) begin buf_add(c); tok_out(bsl_pkg::K_NE, 32'd0); return 0; end
        tok_out(bsl_pkg::K_LT, 32'd0); return 1;
      end
      bsl_pkg::M_STR_OPEN: begin
        if (c == 8'h00) begin
          tok_out(bsl_pkg::K_STR, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
        end
        lx_held = c; lx_mode = bsl_pkg::M_STR_ONE; return 0;
      end
      bsl_pkg::M_STR_ONE: begin
        if (c == 8'h22) begin lx_mode = bsl_pkg::M_STR_TWO; return 0; end
        if (lx_held == 8'h22) begin
          tok_out(bsl_pkg::K_STR, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
        end
        buf_add(lx_held); lx_mode = bsl_pkg::M_STR_BODY; return 1;
      end
      bsl_pkg::M_STR_TWO: begin
        if (c == 8'h43 || c == 8'h63) begin
          buf_add(lx_held); tok_out(bsl_pkg::K_CHAR, 32'd0); lx_mode = bsl_pkg::M_IDLE;
          return 0;
        end
        if (lx_held == 8'h22) begin
          tok_out(bsl_pkg::K_STR, 32'd0); lx_mode = bsl_pkg::M_STR_OPEN; return 1;
        end
        buf_add(lx_held); tok_out(bsl_pkg::K_STR, 32'd0); lx_mode = bsl_pkg::M_IDLE;
        return 1;
      end
      bsl_pkg::M_STR_BODY: begin
        if (c == 8'h22) begin
          tok_out(bsl_pkg::K_STR, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 0;
        end
        if (c == 8'h00) begin
          tok_out(bsl_pkg::K_STR, 32'd0); lx_mode = bsl_pkg::M_IDLE; return 1;
        end
        buf_add(c); return 0;
      end
      default: begin
        lx_mode = bsl_pkg::M_IDLE; tok_begin(c); return 0;
      end
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    for (int g = 0; g < 8; g++)
      if (!scan_step(c)) break;
  endfunction

  // Stimulus helpers
  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return 8'h5f;
  endfunction

  function automatic logic [7:0] rand_hexdig();
    string hd = "0123456789abcdefABCDEF";
    return hd[$urandom_range(0, 21)];
  endfunction

  // Any byte but the quote and end of text
  function automatic logic [7:0] rand_strch();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == 8'h22);
    return c;
  endfunction

  task automatic put_token();
    int n;
    string kw;
    case ($urandom_range(0, 15))
      0, 1: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        src_q.push_back(is_alpha(8'h5f) && $urandom_range(0, 5) == 0 ? 8'h5f
                        : 8'h61 + 8'($urandom_range(0, 25)));
        for (int i = 1; i < n; i++) src_q.push_back(rand_alnum());
      end
      2, 3: begin
        kw = kw_list[$urandom_range(0, 46)];
        for (int i = 0; i < kw.len(); i++)
          src_q.push_back($urandom_range(0, 1) ? kw[i] - 8'd32 : kw[i]);
      end
      4: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) src_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          src_q.push_back(8'h2e);
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) src_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
      end
      5: begin
        put_str($urandom_range(0, 1) ? "&H" : "0x");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) src_q.push_back(rand_hexdig());
      end
      6: src_q.push_back(op_list[$urandom_range(0, 15)]);
      7: begin
        case ($urandom_range(0, 5))
          0: put_str(">="); 1: put_str("<="); 2: put_str("<>");
          3: put_str(">"); 4: put_str("<"); default: put_str("=");
        endcase
      end
      8, 9: begin
        src_q.push_back(8'h22);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) src_q.push_back(rand_strch());
        src_q.push_back(8'h22);
      end
      10: begin
        src_q.push_back(8'h22); src_q.push_back(rand_strch()); src_q.push_back(8'h22);
        src_q.push_back($urandom_range(0, 1) ? 8'h63 : 8'h43);
      end
      11: begin
        src_q.push_back(8'h27);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) src_q.push_back(8'($urandom_range(1, 255)));
        src_q.push_back(8'h0a);
      end
      12: src_q.push_back(8'h0a);
      13: src_q.push_back(8'($urandom_range(0, 255)));
      14: src_q.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'h26);
      default: src_q.push_back(8'h0d);
    endcase
    // separator or none, so tokens also abut
    case ($urandom_range(0, 3))
      0: src_q.push_back(8'h20);
      1: src_q.push_back(8'h09);
      default: ;
    endcase
  endtask

  // Idle percentages by phase of the run
  function automatic int src_idle_pct();
    if (n_sent < thr1) return 17;
    if (n_sent < thr2) return 64;
    return 0;
  endfunction

  function automatic int snk_idle_pct();
    if (n_sent < thr1) return 64;
    if (n_sent < thr2) return 17;
    return 0;
  endfunction

  // Byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct()) begin
          s_axis_tdata  <= src_q.pop_front();
          s_axis_tvalid <= 1'b1;
          n_sent++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Token beat monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    tok_beat_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct());
      if (m_axis_tvalid && m_axis_tready) begin
        n_beats++;
        if (m_axis_tlast) n_tokens++;
        if (beat_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected beat: tdata=%h tuser=%h tlast=%b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          e = beat_q.pop_front();
          if (m_axis_tuser[6:0] !== e.kind || m_axis_tdata[7:0] !== e.ch ||
              m_axis_tuser[7] !== e.valid || m_axis_tdata[23:8] !== e.line ||
              m_axis_tdata[55:24] !== e.hex || m_axis_tdata[56] !== e.trunc ||
              m_axis_tdata[63:57] !== 7'd0 || m_axis_tlast !== e.last) begin
            n_err++;
            if (n_err <= 10) begin
              $display("beat %0d mismatch: exp kind=%0d ch=%h v=%b last=%b line=%0d hex=%h tr=%b",
                       n_beats, e.kind, e.ch, e.valid, e.last, e.line, e.hex, e.trunc);
              $display("  got kind=%0d ch=%h v=%b last=%b line=%0d hex=%h tr=%b pad=%h",
                       m_axis_tuser[6:0], m_axis_tdata[7:0], m_axis_tuser[7],
                       m_axis_tlast, m_axis_tdata[23:8], m_axis_tdata[55:24],
                       m_axis_tdata[56], m_axis_tdata[63:57]);
            end
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // directed: every operator, keywords, numbers, hex forms, strings, char literals
    put_str("+-*/()[]{};.,$#:= > >= < <= <>\t\r\n");
    put_str("IF then ElseIf FALSE x_9 _a\n");
    put_str("0 007 12.5 3. &H &HdeadBEEF1 0x 0x7fFFffff &hx & ");
    put_str("\"\" \"ab\"\"\"\"x\"c\"y\"C\"\"\"c 'note\n");
    put_str("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ ");
    put_str("\"0123456789012345678901234567890123456789\"\n");
    src_q.push_back(8'h80); src_q.push_back(8'hff); src_q.push_back(8'h7f);
    src_q.push_back(8'h40); src_q.push_back(8'h01);
    put_str("\"open\n");
    src_q.push_back(8'h00);
    put_str("'to end");
    src_q.push_back(8'h00);
    // random part up to the item count, ends with end of text
    while (src_q.size() < N_ITEMS - 1) put_token();
    src_q.push_back(8'h00);
    thr1 = src_q.size() / 3;
    thr2 = 2 * src_q.size() / 3;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (src_q.size() == 0 && !s_axis_tvalid);
    wait (beat_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d source bytes lexed into %0d tokens (%0d beats), three idling phases,",
             n_sent, n_tokens, n_beats);
    $display("including truncation, hex forms, strings and char literals; errors: %0d",
             n_err);
    if (n_err == 0 && beat_q.size() == 0) begin
      $display("** basic_source_lexer: PASSED **");
    end else begin
      $display("** basic_source_lexer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("timeout, %0d beats still expected", beat_q.size());
    $display("** basic_source_lexer: FAILED **");
    $finish;
  end

endmodule
